FILE: design/tqwd_pkg.sv
// Shared constants and types for the two-queue weighted dispatcher.
package tqwd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int BURST_BITS  = 4;

    localparam logic [BURST_BITS-1:0] BURST_RESET = 4'd3;

    localparam logic [MODE_BITS-1:0] MODE_ENQ_NORMAL   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ENQ_PRIORITY = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_SERVE        = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_PRIO = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NORM = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NONE = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_ENQ  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_DROP = 3'd4;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_NORM,
        SRC_PRIO
    } src_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic load;
    } ctrl_cmd_t;

endpackage

FILE: design/tqwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tqwd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/tqwd_datapath.sv
// Queue stores, pointers, burst counter and result registers.
module tqwd_datapath #(
    parameter int QUEUE_DEPTH = tqwd_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tqwd_pkg::ID_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tqwd_pkg::ctrl_cmd_t              cmd,
    input  logic                             cfg_we,
    input  logic [tqwd_pkg::BURST_BITS-1:0]  cfg_data,
    input  logic [tqwd_pkg::MODE_BITS-1:0]   s_mode,
    input  logic [ID_BITS-1:0]               s_ticket_id,
    output logic [tqwd_pkg::STATUS_BITS-1:0] m_status,
    output logic [ID_BITS-1:0]               m_served_id
);
    import tqwd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [AW-1:0]          n_head_reg, n_head_next, p_head_reg, p_head_next;
    logic [CW-1:0]          n_count_reg, n_count_next, p_count_reg, p_count_next;
    logic [BURST_BITS-1:0]  burst_reg, burst_next, limit_reg;
    logic [STATUS_BITS-1:0] res_status_reg, res_status_next;
    src_t                   res_src_reg, res_src_next;
    logic [STATUS_BITS-1:0] m_status_reg;
    logic [ID_BITS-1:0]     m_served_id_reg;

    logic          n_empty, p_empty, n_full, p_full;
    logic [AW-1:0] n_tail, p_tail, n_head_inc, p_head_inc;
    logic          n_we, p_we, n_re, p_re;
    logic [ID_BITS-1:0] n_rd, p_rd;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                                input logic [CW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b[AW-1:0]};
        if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (AW+1)'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign n_empty    = (n_count_reg == '0);
    assign p_empty    = (p_count_reg == '0);
    assign n_full     = (n_count_reg == CW'(QUEUE_DEPTH));
    assign p_full     = (p_count_reg == CW'(QUEUE_DEPTH));
    assign n_tail     = wrap_add(n_head_reg, n_count_reg);
    assign p_tail     = wrap_add(p_head_reg, p_count_reg);
    assign n_head_inc = wrap_add(n_head_reg, CW'(1));
    assign p_head_inc = wrap_add(p_head_reg, CW'(1));

    always_comb begin
        n_head_next     = n_head_reg;
        p_head_next     = p_head_reg;
        n_count_next    = n_count_reg;
        p_count_next    = p_count_reg;
        burst_next      = burst_reg;
        res_status_next = res_status_reg;
        res_src_next    = res_src_reg;
        n_we = 1'b0;
        p_we = 1'b0;
        n_re = 1'b0;
        p_re = 1'b0;
        if (cmd.take) begin
            res_src_next    = SRC_NONE;
            res_status_next = ST_NONE;
            case (s_mode)
                MODE_ENQ_NORMAL: begin
                    if (n_full) begin
                        res_status_next = ST_DROP;
                    end else begin
                        res_status_next = ST_ENQ;
                        n_we            = 1'b1;
                        n_count_next    = n_count_reg + CW'(1);
                    end
                end
                MODE_ENQ_PRIORITY: begin
                    if (p_full) begin
                        res_status_next = ST_DROP;
                    end else begin
                        res_status_next = ST_ENQ;
                        p_we            = 1'b1;
                        p_count_next    = p_count_reg + CW'(1);
                    end
                end
                MODE_SERVE: begin
                    if (n_empty && p_empty) begin
                        burst_next = '0;
                    end else if (n_empty || (!p_empty && burst_reg < limit_reg)) begin
                        // priority side; the counter moves only when normal also waits
                        res_status_next = ST_PRIO;
                        res_src_next    = SRC_PRIO;
                        p_re            = 1'b1;
                        p_head_next     = p_head_inc;
                        p_count_next    = p_count_reg - CW'(1);
                        if (!n_empty) begin
                            burst_next = burst_reg + BURST_BITS'(1);
                        end
                    end else begin
                        res_status_next = ST_NORM;
                        res_src_next    = SRC_NORM;
                        n_re            = 1'b1;
                        n_head_next     = n_head_inc;
                        n_count_next    = n_count_reg - CW'(1);
                        burst_next      = '0;
                    end
                end
                default: begin
                    res_status_next = ST_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_head_reg  <= '0;
            p_head_reg  <= '0;
            n_count_reg <= '0;
            p_count_reg <= '0;
            burst_reg   <= '0;
            limit_reg   <= BURST_RESET;
        end else begin
            n_head_reg  <= n_head_next;
            p_head_reg  <= p_head_next;
            n_count_reg <= n_count_next;
            p_count_reg <= p_count_next;
            burst_reg   <= burst_next;
            if (cfg_we) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_src_reg    <= res_src_next;
        if (cmd.load) begin
            m_status_reg <= res_status_reg;
            case (res_src_reg)
                SRC_NORM: m_served_id_reg <= n_rd;
                SRC_PRIO: m_served_id_reg <= p_rd;
                default:  m_served_id_reg <= '0;
            endcase
        end
    end

    tqwd_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_normal_ram (
        .aclk    (aclk),
        .wr_en   (n_we),
        .wr_addr (n_tail),
        .wr_data (s_ticket_id),
        .rd_en   (n_re),
        .rd_addr (n_head_reg),
        .rd_data (n_rd)
    );

    tqwd_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_priority_ram (
        .aclk    (aclk),
        .wr_en   (p_we),
        .wr_addr (p_tail),
        .wr_data (s_ticket_id),
        .rd_en   (p_re),
        .rd_addr (p_head_reg),
        .rd_data (p_rd)
    );

    assign m_status    = m_status_reg;
    assign m_served_id = m_served_id_reg;

endmodule

FILE: design/tqwd_ctrl.sv
// Controller: sequences one word through the datapath and owns the output valid.
module tqwd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tqwd_pkg::ctrl_cmd_t cmd
);
    import tqwd_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CTRL_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            CTRL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = CTRL_FINISH;
                end
            end
            CTRL_FINISH: begin
                // read data is ready now; wait only for a free output slot
                if (!m_valid_reg || m_ready) begin
                    cmd.load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = CTRL_IDLE;
                end
            end
            default: begin
                state_next = CTRL_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: design/two_queue_weighted_dispatcher.sv
// Top level of the two-queue weighted dispatcher.
// Input channel s_*: one word per command. s_mode 0 enqueues s_ticket_id in the
// normal queue, 1 in the priority queue, 2 serves the next ticket.
// Result channel m_*: exactly one word per command, m_status and m_served_id.
// Config channel cfg_*: cfg_data sets the priority burst limit; always ready,
// to be written only while no command is in flight.
// Each command is accepted, then passes through the queue RAM's registered read,
// after which the result moves into the output register. No new command is taken
// until that result is loaded into the output register, which also raises m_valid.
// The output register holds a finished word while the next command is taken;
// if the receiver stalls longer, the block holds its result and s_ready stays
// low until the output register frees up.
// Reset empties both queues, clears the burst count and sets the limit to 3.
// Queue contents are not cleared; only written entries are ever read.
module two_queue_weighted_dispatcher #(
    parameter int QUEUE_DEPTH = tqwd_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = tqwd_pkg::ID_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tqwd_pkg::MODE_BITS-1:0]   s_mode,
    input  logic [ID_BITS-1:0]               s_ticket_id,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tqwd_pkg::STATUS_BITS-1:0] m_status,
    output logic [ID_BITS-1:0]               m_served_id,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tqwd_pkg::BURST_BITS-1:0]  cfg_data
);
    import tqwd_pkg::*;

    ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    tqwd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    tqwd_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_we      (cfg_valid),
        .cfg_data    (cfg_data),
        .s_mode      (s_mode),
        .s_ticket_id (s_ticket_id),
        .m_status    (m_status),
        .m_served_id (m_served_id)
    );

endmodule

FILE: design/tqwd_checker.sv
// Port-level checks for the dispatcher, bound to the top level.
module tqwd_port_checks #(
    parameter int ID_BITS = tqwd_pkg::ID_BITS_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [tqwd_pkg::STATUS_BITS-1:0] m_status,
    input logic [ID_BITS-1:0]               m_served_id
);
    import tqwd_pkg::*;

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_served_id))
        else $error("stalled result word changed");

    a_id_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_PRIO && m_status != ST_NORM |-> m_served_id == '0)
        else $error("served id nonzero without a serve");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_DROP)
        else $error("status code out of range");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken two cycles in a row");

endmodule

bind two_queue_weighted_dispatcher tqwd_port_checks #(.ID_BITS(ID_BITS)) u_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_served_id (m_served_id)
);
